/* hw/rtl/fcw_pkg.sv */
package fcw_pkg;

    // fixed field widths
    localparam int unsigned ACTION_W  = 2;
    localparam int unsigned INDEX_W   = 12;
    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned CLUSTER_W = 28;
    localparam int unsigned SECTOR_W  = 35;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 22;

    // register widths
    localparam int unsigned SPC_W = 7;
    localparam int unsigned RSV_W = 16;
    localparam int unsigned NF_W  = 8;
    localparam int unsigned SPF_W = 22;
    localparam int unsigned FATPROD_W = NF_W + SPF_W;

    // run length limit and counter width
    localparam logic [SPC_W-1:0] MAX_RUN = 7'd64;
    localparam int unsigned RUN_CNT_W = 6;

    // end-of-chain marker
    localparam logic [VALUE_W-1:0] END_OF_CHAIN = 32'h0FFF_FFFF;

    // command queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = 1;
    localparam int unsigned QUEUE_CW    = 2;

    // input action codes
    localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_START = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_NEXT  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NONE  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RSV = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NF  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPF = 2'd3;

    // register reset values
    localparam logic [SPC_W-1:0] SPC_RESET = 7'd1;
    localparam logic [RSV_W-1:0] RSV_RESET = 16'd32;
    localparam logic [NF_W-1:0]  NF_RESET  = 8'd2;
    localparam logic [SPF_W-1:0] SPF_RESET = 22'd0;

    typedef enum logic [STATUS_W-1:0] {
        ST_SECTOR  = 2'd0,
        ST_DONE    = 2'd1,
        ST_CORRUPT = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_START,
        CMD_NEXT
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind              kind;
        logic                   empty;
        logic [INDEX_W-1:0]     index;
        logic [VALUE_W-1:0]     value;
        logic [CLUSTER_W-1:0]   start;
    } t_cmd;

    typedef struct packed {
        logic [SPC_W-1:0] spc;
        logic [RSV_W-1:0] rsv;
        logic [NF_W-1:0]  nf;
        logic [SPF_W-1:0] spf;
    } t_cfg;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_SUM,
        BK_EMIT,
        BK_STAT
    } t_back_state;

endpackage

/* hw/rtl/fcw_in_if.sv */
interface fcw_in_if;
    logic                           valid;
    logic                           ready;
    logic [fcw_pkg::ACTION_W-1:0]   action;
    logic [fcw_pkg::INDEX_W-1:0]    entry_index;
    logic [fcw_pkg::VALUE_W-1:0]    entry_value;
    logic [fcw_pkg::CLUSTER_W-1:0]  start_cluster;

    modport source (
        output valid, action, entry_index, entry_value, start_cluster,
        input  ready
    );
    modport sink (
        input  valid, action, entry_index, entry_value, start_cluster,
        output ready
    );
endinterface

/* hw/rtl/fcw_out_if.sv */
interface fcw_out_if;
    logic                           valid;
    logic                           ready;
    logic [fcw_pkg::SECTOR_W-1:0]   sector_number;
    logic                           last_in_run;
    logic [fcw_pkg::STATUS_W-1:0]   status;

    modport source (
        output valid, sector_number, last_in_run, status,
        input  ready
    );
    modport sink (
        input  valid, sector_number, last_in_run, status,
        output ready
    );
endinterface

/* hw/rtl/fat32_cluster_chain_sector_walker.sv */
// channel   dir  handshake      payload
// i_in      in   valid/ready    action, entry_index, entry_value, start_cluster
// o_out     out  valid/ready    sector_number, last_in_run, status
// i_cfg_*   in   write enable   i_cfg_index selects register, i_cfg_data
//
// a next item on an active chain is popped, then steps through multiply and sum, then emits
// one sector per cycle while the output is free; a finished chain pops, then emits its status
// loads and starts retire when popped in the idle state; a 2-entry command queue decouples intake
// reset clears the queue, chain state and output valid; the table has no reset
// a stalled output holds the sequencer, the queue then fills and lowers i_in.ready
module fat32_cluster_chain_sector_walker #(
    parameter int unsigned TABLE_ENTRIES = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    fcw_in_if.sink                            i_in,
    fcw_out_if.source                         o_out,
    input  logic                              i_cfg_we,
    input  logic [fcw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fcw_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    fcw_pkg::t_cfg r_cfg, n_cfg;
    fcw_pkg::t_cmd push_cmd;
    fcw_pkg::t_cmd head_cmd;
    logic          push;
    logic          full;
    logic          head_valid;
    logic          pop;

    // configuration register writes
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                fcw_pkg::CFG_SPC: n_cfg.spc = i_cfg_data[fcw_pkg::SPC_W-1:0];
                fcw_pkg::CFG_RSV: n_cfg.rsv = i_cfg_data[fcw_pkg::RSV_W-1:0];
                fcw_pkg::CFG_NF:  n_cfg.nf  = i_cfg_data[fcw_pkg::NF_W-1:0];
                fcw_pkg::CFG_SPF: n_cfg.spf = i_cfg_data[fcw_pkg::SPF_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spc <= fcw_pkg::SPC_RESET;
            r_cfg.rsv <= fcw_pkg::RSV_RESET;
            r_cfg.nf  <= fcw_pkg::NF_RESET;
            r_cfg.spf <= fcw_pkg::SPF_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // intake and classification
    fcw_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_cmd  (push_cmd)
    );

    // command queue
    fcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_cmd   (head_cmd)
    );

    // table, chain state and sector sequencer
    fcw_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (head_valid),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

/* hw/rtl/fcw_front.sv */
module fcw_front #(
    parameter int unsigned TABLE_ENTRIES = 4096
) (
    fcw_in_if.sink          i_in,
    input  logic            i_full,
    output logic            o_push,
    output fcw_pkg::t_cmd   o_cmd
);

    localparam logic [fcw_pkg::CLUSTER_W:0] TE = (fcw_pkg::CLUSTER_W+1)'(TABLE_ENTRIES);

    logic index_ok;
    logic start_empty;
    logic keep;

    assign i_in.ready = !i_full;

    // loads beyond the table and unknown actions are dropped here
    assign index_ok    = (fcw_pkg::CLUSTER_W+1)'(i_in.entry_index) < TE;
    assign start_empty = (i_in.start_cluster < fcw_pkg::CLUSTER_W'(2)) ||
                         ({4'd0, i_in.start_cluster} == fcw_pkg::END_OF_CHAIN);

    always_comb begin
        keep        = 1'b0;
        o_cmd.kind  = fcw_pkg::CMD_NEXT;
        o_cmd.empty = start_empty;
        o_cmd.index = i_in.entry_index;
        o_cmd.value = i_in.entry_value;
        o_cmd.start = i_in.start_cluster;
        unique case (i_in.action)
            fcw_pkg::ACT_LOAD: begin
                keep       = index_ok;
                o_cmd.kind = fcw_pkg::CMD_LOAD;
            end
            fcw_pkg::ACT_START: begin
                keep       = 1'b1;
                o_cmd.kind = fcw_pkg::CMD_START;
            end
            fcw_pkg::ACT_NEXT: begin
                keep       = 1'b1;
                o_cmd.kind = fcw_pkg::CMD_NEXT;
            end
            fcw_pkg::ACT_NONE: begin
                keep       = 1'b0;
                o_cmd.kind = fcw_pkg::CMD_NEXT;
            end
        endcase
    end

    assign o_push = i_in.valid && !i_full && keep;

endmodule

/* hw/rtl/fcw_queue.sv */
module fcw_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  fcw_pkg::t_cmd   i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output fcw_pkg::t_cmd   o_cmd
);

    fcw_pkg::t_cmd r_slot [fcw_pkg::QUEUE_DEPTH];
    logic [fcw_pkg::QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [fcw_pkg::QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [fcw_pkg::QUEUE_CW-1:0] r_count, n_count;

    assign o_full  = r_count == fcw_pkg::QUEUE_CW'(fcw_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_slot[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

/* hw/rtl/fcw_back.sv */
module fcw_back #(
    parameter int unsigned TABLE_ENTRIES = 4096
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fcw_pkg::t_cfg   i_cfg,
    input  logic            i_valid,
    input  fcw_pkg::t_cmd   i_cmd,
    output logic            o_pop,
    fcw_out_if.source       o_out
);

    localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [fcw_pkg::CLUSTER_W:0] TE_C = (fcw_pkg::CLUSTER_W+1)'(TABLE_ENTRIES);
    localparam logic [fcw_pkg::VALUE_W:0]   TE_L = (fcw_pkg::VALUE_W+1)'(TABLE_ENTRIES);

    // allocation table
    logic [fcw_pkg::VALUE_W-1:0] r_fat [TABLE_ENTRIES];
    logic [fcw_pkg::VALUE_W-1:0] r_rdata;

    fcw_pkg::t_back_state r_state, n_state;
    logic [fcw_pkg::CLUSTER_W-1:0] r_cluster, n_cluster;
    logic                          r_active, n_active;
    logic                          r_fault, n_fault;
    logic [fcw_pkg::RUN_CNT_W-1:0] r_j, n_j;
    logic [fcw_pkg::SECTOR_W-1:0]  r_prod;
    logic [fcw_pkg::FATPROD_W-1:0] r_fatprod;
    logic [fcw_pkg::SECTOR_W-1:0]  r_sector, n_sector;

    logic                          r_out_valid, n_out_valid;
    logic [fcw_pkg::SECTOR_W-1:0]  r_out_sector, n_out_sector;
    logic                          r_out_last, n_out_last;
    logic [fcw_pkg::STATUS_W-1:0]  r_out_status, n_out_status;

    logic [fcw_pkg::SPC_W-1:0]     run;
    logic                          out_free;
    logic                          last_sector;
    logic                          in_table;
    logic                          link_end;
    logic                          link_bad;
    logic [fcw_pkg::CLUSTER_W-1:0] cluster_ext;
    logic [AW-1:0]                 rd_addr;
    logic [fcw_pkg::CLUSTER_W-1:0] idx_ext;
    logic [AW-1:0]                 wr_addr;

    // run length clamped to one..sixty-four
    always_comb begin
        if (i_cfg.spc == '0) begin
            run = fcw_pkg::SPC_W'(1);
        end else if (i_cfg.spc > fcw_pkg::MAX_RUN) begin
            run = fcw_pkg::MAX_RUN;
        end else begin
            run = i_cfg.spc;
        end
    end

    assign out_free    = !r_out_valid || o_out.ready;
    assign last_sector = (fcw_pkg::SPC_W'(r_j) + 1'b1) == run;

    // link classification
    assign cluster_ext = r_cluster;
    assign rd_addr     = cluster_ext[AW-1:0];
    assign in_table    = {1'b0, r_cluster} < TE_C;
    assign link_end    = in_table && (r_rdata == fcw_pkg::END_OF_CHAIN);
    assign link_bad    = !in_table || (r_rdata < fcw_pkg::VALUE_W'(2)) ||
                         ({1'b0, r_rdata} >= TE_L);

    assign idx_ext = fcw_pkg::CLUSTER_W'(i_cmd.index);
    assign wr_addr = idx_ext[AW-1:0];

    // table write on a popped load, registered read at the current cluster
    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.kind == fcw_pkg::CMD_LOAD) begin
            r_fat[wr_addr] <= i_cmd.value;
        end
        r_rdata <= r_fat[rd_addr];
    end

    // data region offset; config must stay stable while items run, the block does not enforce it
    always_ff @(posedge i_clk) begin
        r_fatprod <= i_cfg.nf * i_cfg.spf;
        if (r_state == fcw_pkg::BK_MUL) begin
            r_prod <= fcw_pkg::SECTOR_W'(r_cluster - fcw_pkg::CLUSTER_W'(2)) *
                      fcw_pkg::SECTOR_W'(run);
        end
    end

    // sequencer next state and outputs
    always_comb begin
        n_state      = r_state;
        n_cluster    = r_cluster;
        n_active     = r_active;
        n_fault      = r_fault;
        n_j          = r_j;
        n_sector     = r_sector;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_sector = r_out_sector;
        n_out_last   = r_out_last;
        n_out_status = r_out_status;
        o_pop        = 1'b0;

        unique case (r_state)
            fcw_pkg::BK_IDLE: begin
                if (i_valid) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.kind)
                        fcw_pkg::CMD_LOAD: begin
                            n_state = fcw_pkg::BK_IDLE;
                        end
                        fcw_pkg::CMD_START: begin
                            n_fault = 1'b0;
                            if (i_cmd.empty) begin
                                n_active = 1'b0;
                            end else begin
                                n_active  = 1'b1;
                                n_cluster = i_cmd.start;
                            end
                        end
                        fcw_pkg::CMD_NEXT: begin
                            n_state = r_active ? fcw_pkg::BK_MUL : fcw_pkg::BK_STAT;
                        end
                        default: begin
                            n_state = fcw_pkg::BK_IDLE;
                        end
                    endcase
                end
            end
            fcw_pkg::BK_MUL: begin
                n_state = fcw_pkg::BK_SUM;
            end
            fcw_pkg::BK_SUM: begin
                n_sector = r_prod + fcw_pkg::SECTOR_W'(i_cfg.rsv) +
                           fcw_pkg::SECTOR_W'(r_fatprod);
                n_j      = '0;
                n_state  = fcw_pkg::BK_EMIT;
            end
            fcw_pkg::BK_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_sector = r_sector;
                    n_out_last   = last_sector;
                    n_out_status = fcw_pkg::ST_SECTOR;
                    n_sector     = r_sector + 1'b1;
                    n_j          = r_j + 1'b1;
                    if (last_sector) begin
                        n_state = fcw_pkg::BK_IDLE;
                        // follow the link
                        if (link_end) begin
                            n_active = 1'b0;
                        end else if (link_bad) begin
                            n_active = 1'b0;
                            n_fault  = 1'b1;
                        end else begin
                            n_cluster = r_rdata[fcw_pkg::CLUSTER_W-1:0];
                        end
                    end
                end
            end
            fcw_pkg::BK_STAT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_sector = '0;
                    n_out_last   = 1'b1;
                    n_out_status = r_fault ? fcw_pkg::ST_CORRUPT : fcw_pkg::ST_DONE;
                    n_state      = fcw_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = fcw_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fcw_pkg::BK_IDLE;
            r_cluster   <= '0;
            r_active    <= 1'b0;
            r_fault     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cluster   <= n_cluster;
            r_active    <= n_active;
            r_fault     <= n_fault;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_j          <= n_j;
        r_sector     <= n_sector;
        r_out_sector <= n_out_sector;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.sector_number = r_out_sector;
    assign o_out.last_in_run   = r_out_last;
    assign o_out.status        = r_out_status;

endmodule

/* sim/testbench.sv */
module testbench;

    localparam int unsigned TABLE        = 4096;
    localparam int unsigned DRAIN_CYCLES = 80;
    localparam int unsigned QUIET_LIMIT  = 3000;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [fcw_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [fcw_pkg::CFG_DATA_W-1:0] i_cfg_data;

    // both sides stop idling while this is set
    bit          steady;
    int unsigned sent;

    fcw_in_if  in_if ();
    fcw_out_if out_if ();

    fat32_cluster_chain_sector_walker #(
        .TABLE_ENTRIES(TABLE)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    typedef struct packed {
        logic [fcw_pkg::SECTOR_W-1:0] sector;
        logic                         last;
        fcw_pkg::t_status             status;
    } t_sector_rec;

    // chain walk predictor and the queue of sectors it still expects
    class t_sector_scoreboard;
        logic [fcw_pkg::VALUE_W-1:0]   links [int unsigned];
        logic [fcw_pkg::CLUSTER_W-1:0] cluster;
        bit                            active;
        bit                            fault;
        logic [fcw_pkg::SPC_W-1:0]     spc;
        logic [fcw_pkg::RSV_W-1:0]     rsv;
        logic [fcw_pkg::NF_W-1:0]      nf;
        logic [fcw_pkg::SPF_W-1:0]     spf;
        t_sector_rec                   pending [$];
        int unsigned                   errors;

        function new();
            cluster = '0;
            active  = 1'b0;
            fault   = 1'b0;
            spc     = fcw_pkg::SPC_RESET;
            rsv     = fcw_pkg::RSV_RESET;
            nf      = fcw_pkg::NF_RESET;
            spf     = fcw_pkg::SPF_RESET;
            errors  = 0;
        endfunction

        function void set_reg(logic [fcw_pkg::CFG_IDX_W-1:0] index,
                              logic [fcw_pkg::CFG_DATA_W-1:0] data);
            case (index)
                fcw_pkg::CFG_SPC: spc = data[fcw_pkg::SPC_W-1:0];
                fcw_pkg::CFG_RSV: rsv = data[fcw_pkg::RSV_W-1:0];
                fcw_pkg::CFG_NF:  nf  = data[fcw_pkg::NF_W-1:0];
                fcw_pkg::CFG_SPF: spf = data[fcw_pkg::SPF_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_input(logic [fcw_pkg::ACTION_W-1:0] action,
                                 logic [fcw_pkg::INDEX_W-1:0] index,
                                 logic [fcw_pkg::VALUE_W-1:0] value,
                                 logic [fcw_pkg::CLUSTER_W-1:0] start);
            int unsigned                 run;
            longint unsigned             base;
            logic [fcw_pkg::VALUE_W-1:0] link;
            t_sector_rec                 rec;
            case (action)
                fcw_pkg::ACT_LOAD: begin
                    if (index < TABLE) links[index] = value;
                end
                fcw_pkg::ACT_START: begin
                    fault = 1'b0;
                    if (start < 2 || {4'b0, start} == fcw_pkg::END_OF_CHAIN) begin
                        active = 1'b0;
                    end else begin
                        cluster = start;
                        active  = 1'b1;
                    end
                end
                fcw_pkg::ACT_NEXT: begin
                    if (!active) begin
                        rec.sector = '0;
                        rec.last   = 1'b1;
                        rec.status = fault ? fcw_pkg::ST_CORRUPT : fcw_pkg::ST_DONE;
                        pending = {pending, rec};
                    end else begin
                        // out-of-range run lengths clamp to 1..64
                        run = (spc == 0) ? 1 : (spc > fcw_pkg::MAX_RUN) ? fcw_pkg::MAX_RUN : spc;
                        base = (64'(cluster) - 64'd2) * 64'(run) + 64'(rsv)
                             + 64'(nf) * 64'(spf);
                        for (int unsigned j = 0; j < run; j++) begin
                            rec.sector = fcw_pkg::SECTOR_W'(base + j);
                            rec.last   = (j + 1 == run);
                            rec.status = fcw_pkg::ST_SECTOR;
                            pending = {pending, rec};
                        end
                        // follow the link; clusters past the table count as corrupt
                        link = (cluster < TABLE) ? links[cluster] : '0;
                        if (link == fcw_pkg::END_OF_CHAIN) begin
                            active = 1'b0;
                        end else if (link < 2 || link >= TABLE) begin
                            active = 1'b0;
                            fault  = 1'b1;
                        end else begin
                            cluster = link[fcw_pkg::CLUSTER_W-1:0];
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [fcw_pkg::SECTOR_W-1:0] sector, logic last,
                                   logic [fcw_pkg::STATUS_W-1:0] status);
            t_sector_rec want;
            if (pending.size() == 0) begin
                $error("unexpected result: sector_number %0d status %0d", sector, status);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (sector !== want.sector) begin
                $error("sector_number: expected %0d, got %0d", want.sector, sector);
                errors++;
            end
            if (last !== want.last) begin
                $error("last_in_run: expected %0d, got %0d", want.last, last);
                errors++;
            end
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                errors++;
            end
        endfunction
    endclass

    t_sector_scoreboard sb = new();

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result sink with random back-pressure
    always @(posedge i_clk) begin
        out_if.ready <= steady || ($urandom_range(99) >= 25);
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_result(out_if.sector_number, out_if.last_in_run, out_if.status);
    end

    // ends the run when nothing transfers for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("testbench NOT OK");
        $finish;
    end

    // one input transfer, with random idle cycles ahead of it unless steady is set
    task automatic send_item(input logic [fcw_pkg::ACTION_W-1:0] action,
                             input logic [fcw_pkg::INDEX_W-1:0] index,
                             input logic [fcw_pkg::VALUE_W-1:0] value,
                             input logic [fcw_pkg::CLUSTER_W-1:0] start);
        if (!steady) begin
            while ($urandom_range(99) < 25) begin
                in_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_if.valid         <= 1'b1;
        in_if.action        <= action;
        in_if.entry_index   <= index;
        in_if.entry_value   <= value;
        in_if.start_cluster <= start;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sb.note_input(action, index, value, start);
        if (action != fcw_pkg::ACT_NONE) sent++;
    endtask

    function automatic logic [fcw_pkg::VALUE_W-1:0] pick_link();
        case ($urandom_range(3))
            0:       return fcw_pkg::END_OF_CHAIN;
            1:       return fcw_pkg::VALUE_W'($urandom_range(TABLE - 1, 2));
            2:       return fcw_pkg::VALUE_W'($urandom_range(1));
            default: return $urandom;
        endcase
    endfunction

    // next item; the current cluster's entry is loaded first if it was never written
    task automatic send_next();
        if (sb.active && sb.cluster < TABLE && !sb.links.exists(sb.cluster))
            send_item(fcw_pkg::ACT_LOAD, sb.cluster[fcw_pkg::INDEX_W-1:0], pick_link(),
                      fcw_pkg::CLUSTER_W'($urandom));
        send_item(fcw_pkg::ACT_NEXT, fcw_pkg::INDEX_W'($urandom), $urandom,
                  fcw_pkg::CLUSTER_W'($urandom));
    endtask

    // build a linked chain in the table, start it and walk it to its end or beyond
    task automatic send_chain();
        int unsigned                 nodes [$];
        int unsigned                 len;
        int unsigned                 c;
        bit                          dup;
        logic [fcw_pkg::VALUE_W-1:0] tail;
        logic [fcw_pkg::VALUE_W-1:0] link;
        len = $urandom_range(6, 1);
        while (nodes.size() < len) begin
            c = $urandom_range(TABLE - 1, 2);
            dup = 1'b0;
            for (int k = 0; k < nodes.size(); k++)
                if (nodes[k] == c) dup = 1'b1;
            if (!dup) nodes = {nodes, c};
        end
        case ($urandom_range(9))
            6:       tail = fcw_pkg::VALUE_W'($urandom_range(1));
            7:       tail = fcw_pkg::VALUE_W'($urandom_range(32'hFFFF_FFFF, TABLE));
            8:       tail = fcw_pkg::VALUE_W'(nodes[0]);
            default: tail = fcw_pkg::END_OF_CHAIN;
        endcase
        for (int k = len - 1; k >= 0; k--) begin
            link = (k + 1 < len) ? fcw_pkg::VALUE_W'(nodes[k + 1]) : tail;
            send_item(fcw_pkg::ACT_LOAD, fcw_pkg::INDEX_W'(nodes[k]), link,
                      fcw_pkg::CLUSTER_W'($urandom));
        end
        send_item(fcw_pkg::ACT_START, fcw_pkg::INDEX_W'($urandom), $urandom,
                  fcw_pkg::CLUSTER_W'(nodes[0]));
        repeat (len + $urandom_range(2)) begin
            if ($urandom_range(9) == 0)
                send_item(fcw_pkg::ACT_NONE, fcw_pkg::INDEX_W'($urandom), $urandom,
                          fcw_pkg::CLUSTER_W'($urandom));
            send_next();
        end
    endtask

    // mostly chains built in the table, the rest loose items of every kind
    task automatic run_random(input int unsigned quota);
        int unsigned                   stop;
        logic [fcw_pkg::CLUSTER_W-1:0] start;
        stop = sent + quota;
        while (sent < stop) begin
            case ($urandom_range(4))
                0:       start = fcw_pkg::CLUSTER_W'($urandom_range(1));
                1:       start = fcw_pkg::END_OF_CHAIN[fcw_pkg::CLUSTER_W-1:0];
                2:       start = fcw_pkg::CLUSTER_W'($urandom);
                default: start = fcw_pkg::CLUSTER_W'($urandom_range(TABLE - 1, 2));
            endcase
            if ($urandom_range(99) < 65) begin
                send_chain();
            end else begin
                case ($urandom_range(3))
                    0: send_item(fcw_pkg::ACT_LOAD, fcw_pkg::INDEX_W'($urandom), $urandom,
                                 fcw_pkg::CLUSTER_W'($urandom));
                    1: send_item(fcw_pkg::ACT_START, fcw_pkg::INDEX_W'($urandom), $urandom,
                                 start);
                    2: send_next();
                    default: send_item(fcw_pkg::ACT_NONE, fcw_pkg::INDEX_W'($urandom),
                                       $urandom, start);
                endcase
            end
        end
    endtask

    // let every expected sector arrive and the back end go quiet
    task automatic drain();
        in_if.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [fcw_pkg::CFG_IDX_W-1:0] index,
                             input logic [fcw_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        sb.set_reg(index, data);
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [fcw_pkg::SPC_W-1:0] spc,
                              input logic [fcw_pkg::RSV_W-1:0] rsv,
                              input logic [fcw_pkg::NF_W-1:0] nf,
                              input logic [fcw_pkg::SPF_W-1:0] spf);
        write_reg(fcw_pkg::CFG_SPC, fcw_pkg::CFG_DATA_W'(spc));
        write_reg(fcw_pkg::CFG_RSV, fcw_pkg::CFG_DATA_W'(rsv));
        write_reg(fcw_pkg::CFG_NF, fcw_pkg::CFG_DATA_W'(nf));
        write_reg(fcw_pkg::CFG_SPF, fcw_pkg::CFG_DATA_W'(spf));
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        steady              = 1'b0;
        sent                = 0;
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_index         <= '0;
        i_cfg_data          <= '0;
        in_if.valid         <= 1'b0;
        in_if.action        <= fcw_pkg::ACT_NONE;
        in_if.entry_index   <= '0;
        in_if.entry_value   <= '0;
        in_if.start_cluster <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty chains, unknown action, normal end, corrupt links
        send_item(fcw_pkg::ACT_NEXT, '0, '0, '0);
        send_item(fcw_pkg::ACT_NONE, '1, '1, '1);
        send_item(fcw_pkg::ACT_START, '0, '0, 28'd0);
        send_item(fcw_pkg::ACT_NEXT, '0, '0, '0);
        send_item(fcw_pkg::ACT_START, '0, '0, 28'd1);
        send_item(fcw_pkg::ACT_START, '0, '0, fcw_pkg::END_OF_CHAIN[fcw_pkg::CLUSTER_W-1:0]);
        send_item(fcw_pkg::ACT_NEXT, '0, '0, '0);
        send_item(fcw_pkg::ACT_LOAD, 12'd2, 32'd3, '0);
        send_item(fcw_pkg::ACT_LOAD, 12'd3, fcw_pkg::END_OF_CHAIN, '0);
        send_item(fcw_pkg::ACT_START, '0, '0, 28'd2);
        repeat (3) send_next();
        send_item(fcw_pkg::ACT_LOAD, 12'd4, 32'd0, '0);
        send_item(fcw_pkg::ACT_START, '0, '0, 28'd4);
        repeat (2) send_next();
        send_item(fcw_pkg::ACT_LOAD, 12'd4095, 32'hFFFF_FFFF, '0);
        send_item(fcw_pkg::ACT_START, '0, '0, 28'd4095);
        send_next();
        send_item(fcw_pkg::ACT_LOAD, 12'd5, 32'd1, '0);
        send_item(fcw_pkg::ACT_START, '0, '0, 28'd5);
        send_next();
        send_item(fcw_pkg::ACT_START, '0, '0, 28'h0FF_FFFE);
        repeat (2) send_next();
        run_random(12);
        drain();

        // extreme settings, no idling on either side
        steady = 1'b1;
        set_config(7'd0, 16'hFFFF, 8'd255, 22'h3F_FFFF);
        run_random(12);
        drain();
        steady = 1'b0;

        set_config(7'd64, 16'd0, 8'd1, 22'd2097152);
        run_random(12);
        drain();

        set_config(7'd127, 16'($urandom), 8'($urandom_range(255, 1)),
                   22'($urandom_range(2097152)));
        run_random(12);
        drain();

        set_config(7'($urandom_range(8, 1)), 16'($urandom), 8'($urandom_range(255, 1)),
                   22'($urandom_range(2097152)));
        run_random(12);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule

/* filelist.f */
hw/rtl/fcw_pkg.sv
hw/rtl/fcw_in_if.sv
hw/rtl/fcw_out_if.sv
hw/rtl/fcw_front.sv
hw/rtl/fcw_queue.sv
hw/rtl/fcw_back.sv
hw/rtl/fat32_cluster_chain_sector_walker.sv
sim/testbench.sv
